// ===== rtl/cllfp_pkg.sv =====
`timescale 1ns / 1ps

package cllfp_pkg;

    localparam int DATA_W = 32;

    // operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_WALK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic                     item_valid;
        logic                     last;
        logic                     list_empty;
        logic                     pool_full;
        logic [1:0]               status;
    } out_item_t;

endpackage

// ===== rtl/cllfp_ram.sv =====
`timescale 1ns / 1ps

module cllfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cursor_linked_list_free_pool.sv =====
`timescale 1ns / 1ps
// Push and pop: one link read, then one link write, then S_RESP registers the result.
// Refused push, ignored pop, empty traverse, unused code: from S_IDLE straight to S_RESP.
// Traverse: value read at accept, then one node per cycle (link port) unless output stalls.
// One item at a time: next item accepted once the last result has entered the output register.
// Reset: list empty, free chain 0..CAPACITY-1; link table reads as i+1 via per-entry valid bits.
module cursor_linked_list_free_pool #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cllfp_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cllfp_pkg::out_item_t out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam logic [LW-1:0] CNT_LAST = LW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_WALK,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic [LW-1:0] list_head_reg, list_head_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [1:0]    status_reg, status_next;
    logic [CAPACITY-1:0] lnk_ok_reg, lnk_ok_next;
    logic          lnk_rd_ok_reg;
    logic [AW-1:0] lnk_rd_addr_reg;
    logic          out_valid_reg, out_valid_next;
    cllfp_pkg::out_item_t out_item_reg, out_item_next;

    logic          lnk_we, lnk_re, val_we, val_re;
    logic [AW-1:0] lnk_waddr, lnk_raddr, val_waddr, val_raddr;
    logic [LW-1:0] lnk_wdata, lnk_rdata, link_data;
    logic [cllfp_pkg::DATA_W-1:0] val_rdata;
    logic          out_free, list_empty, pool_full, walk_last;

    cllfp_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .re    (lnk_re),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    cllfp_ram #(.WIDTH(cllfp_pkg::DATA_W), .DEPTH(CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (in_item.value),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // never-written link entries read as index plus one
    assign link_data  = lnk_rd_ok_reg ? lnk_rdata : (LW'(lnk_rd_addr_reg) + LW'(1));
    assign out_free   = !out_valid_reg || out_ready;
    assign list_empty = (list_head_reg == NIL);
    assign pool_full  = (free_head_reg == NIL);
    assign walk_last  = (link_data == NIL) || (cnt_reg == CNT_LAST);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        lnk_ok_next    = lnk_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        lnk_we    = 1'b0;
        lnk_waddr = free_head_reg[AW-1:0];
        lnk_wdata = list_head_reg;
        lnk_re    = 1'b0;
        lnk_raddr = list_head_reg[AW-1:0];
        val_we    = 1'b0;
        val_waddr = free_head_reg[AW-1:0];
        val_re    = 1'b0;
        val_raddr = list_head_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = cllfp_pkg::ST_DONE;
                    state_next  = S_RESP;
                    case (in_item.operation)
                        cllfp_pkg::OP_PUSH:
                        begin
                            if (pool_full)
                            begin
                                status_next = cllfp_pkg::ST_FULL;
                            end
                            else
                            begin
                                lnk_re     = 1'b1;
                                lnk_raddr  = free_head_reg[AW-1:0];
                                val_we     = 1'b1;
                                state_next = S_PUSH;
                            end
                        end
                        cllfp_pkg::OP_POP:
                        begin
                            if (list_empty)
                            begin
                                status_next = cllfp_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                lnk_re     = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        cllfp_pkg::OP_WALK:
                        begin
                            if (!list_empty)
                            begin
                                lnk_re     = 1'b1;
                                val_re     = 1'b1;
                                cnt_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                lnk_we    = 1'b1;
                lnk_waddr = free_head_reg[AW-1:0];
                lnk_wdata = list_head_reg;
                lnk_ok_next[free_head_reg[AW-1:0]] = 1'b1;
                list_head_next = free_head_reg;
                free_head_next = link_data;
                state_next     = S_RESP;
            end
            S_POP:
            begin
                lnk_we    = 1'b1;
                lnk_waddr = list_head_reg[AW-1:0];
                lnk_wdata = free_head_reg;
                lnk_ok_next[list_head_reg[AW-1:0]] = 1'b1;
                free_head_next = list_head_reg;
                list_head_next = link_data;
                state_next     = S_RESP;
            end
            S_WALK:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.data_out    = val_rdata;
                    out_item_next.item_valid  = 1'b1;
                    out_item_next.last        = walk_last;
                    out_item_next.list_empty  = list_empty;
                    out_item_next.pool_full   = pool_full;
                    out_item_next.status      = cllfp_pkg::ST_DONE;
                    if (walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        lnk_re    = 1'b1;
                        val_re    = 1'b1;
                        lnk_raddr = link_data[AW-1:0];
                        val_raddr = link_data[AW-1:0];
                        cnt_next  = cnt_reg + LW'(1);
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.data_out    = '0;
                    out_item_next.item_valid  = 1'b0;
                    out_item_next.last        = 1'b1;
                    out_item_next.list_empty  = list_empty;
                    out_item_next.pool_full   = pool_full;
                    out_item_next.status      = status_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            lnk_ok_reg    <= '0;
            lnk_rd_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            lnk_ok_reg    <= lnk_ok_next;
            out_valid_reg <= out_valid_next;
            if (lnk_re)
            begin
                lnk_rd_ok_reg <= lnk_ok_reg[lnk_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
        if (lnk_re)
        begin
            lnk_rd_addr_reg <= lnk_raddr;
        end
    end

endmodule

// ===== rtl/cllfp_checker.sv =====
`timescale 1ns / 1ps

module cllfp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input cllfp_pkg::out_item_t out_item
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result item changed while stalled");

    // a refused or ignored request is a single, non-data result
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != cllfp_pkg::ST_DONE)
        |-> !out_item.item_valid && out_item.last)
        else $error("error status on a data result");

    a_data_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.item_valid |-> !out_item.list_empty)
        else $error("visited value reported with empty list");

    // with an empty list every node is free
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.list_empty && out_item.pool_full))
        else $error("list empty and pool full at once");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.item_valid |-> out_item.data_out == '0)
        else $error("non-data result carries a value");

endmodule

bind cursor_linked_list_free_pool cllfp_checker u_cllfp_checker (.*);
